// ===== design/fatsd_pkg.sv =====
`default_nettype none

package fatsd_pkg;

  localparam int SampleBits     = 16;
  localparam int PixelCountBits = 25;
  localparam int FrameIndexBits = 16;
  localparam int MaxPlanes      = 16;

  localparam int ThresholdBits = 16;
  localparam int AreaBits      = 17;
  localparam int ChanBits      = 5;
  localparam int PlaneBits     = 4;
  localparam int ProdBits      = PixelCountBits + AreaBits;

  localparam int ApbAddrBits = 4;
  localparam int ApbDataBits = 32;

  localparam logic [ThresholdBits-1:0] ThresholdReset = '0;
  localparam logic [AreaBits-1:0]      AreaReset      = AreaBits'(32768);
  localparam logic [ChanBits-1:0]      SelChanReset   = '1;
  localparam logic [ChanBits-1:0]      ChanCountReset = ChanBits'(1);
  localparam logic [ChanBits-1:0]      MaxPlanesCode  = ChanBits'(MaxPlanes);

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegArea      = 2'd1,
    RegSelChan   = 2'd2,
    RegChanCount = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ThresholdBits-1:0] pix_thresh;
    logic [AreaBits-1:0]      area_fraction;
    logic [ChanBits-1:0]      selected_channel;
    logic [ChanBits-1:0]      channel_count;
  } cfg_t;

  // Closed-out frame counts (or a pass-through beat) from count to classify.
  typedef struct packed {
    logic                      start_run;
    logic                      frame_end;
    logic [PixelCountBits-1:0] hits;
    logic [PixelCountBits-1:0] total;
  } frame_t;

endpackage

`default_nettype wire

// ===== design/fatsd_cfg_regs.sv =====
`default_nettype none

module fatsd_cfg_regs
  import fatsd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ApbAddrBits-1:0] paddr,
  input  wire logic [ApbDataBits-1:0] pwdata,
  output logic      [ApbDataBits-1:0] prdata,
  output logic                        pready,
  output cfg_t                        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegThreshold: cfg_d.pix_thresh       = pwdata[ThresholdBits-1:0];
        RegArea:      cfg_d.area_fraction    = pwdata[AreaBits-1:0];
        RegSelChan:   cfg_d.selected_channel = pwdata[ChanBits-1:0];
        RegChanCount: cfg_d.channel_count    = pwdata[ChanBits-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegThreshold: prdata = ApbDataBits'(cfg_q.pix_thresh);
      RegArea:      prdata = ApbDataBits'(cfg_q.area_fraction);
      RegSelChan:   prdata = ApbDataBits'(cfg_q.selected_channel);
      RegChanCount: prdata = ApbDataBits'(cfg_q.channel_count);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pix_thresh       <= ThresholdReset;
      cfg_q.area_fraction    <= AreaReset;
      cfg_q.selected_channel <= SelChanReset;
      cfg_q.channel_count    <= ChanCountReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/fatsd_count.sv =====
`default_nettype none

module fatsd_count
  import fatsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  start_run_i,
  input  wire logic [SampleBits-1:0] pixel_value_i,
  input  wire logic [PlaneBits-1:0]  plane_i,
  input  wire logic                  frame_end_i,
  output logic                       frame_valid_o,
  input  wire logic                  frame_ready_i,
  output frame_t                     frame_o
);

  localparam logic [PixelCountBits-1:0] CountMax = '1;

  // input register
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_start_q;
  logic [SampleBits-1:0] s1_pix_q;
  logic [PlaneBits-1:0]  s1_plane_q;
  logic                  s1_end_q;

  logic [PixelCountBits-1:0] hits_q, hits_d, total_q, total_d;
  logic [PixelCountBits-1:0] hits_new, total_new;

  logic                s1_adv, in_acc;
  logic                all_planes, take, is_hit;
  logic [ChanBits-1:0] eff_count, chan;

  assign s1_adv     = s1_valid_q & frame_ready_i;
  assign in_stall_o = s1_valid_q & ~frame_ready_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    all_planes = cfg_i.selected_channel[ChanBits-1];
    eff_count  = (cfg_i.channel_count > MaxPlanesCode) ? MaxPlanesCode : cfg_i.channel_count;
    chan       = (!all_planes && cfg_i.selected_channel >= eff_count) ? '0
                                                                       : cfg_i.selected_channel;
    take       = all_planes || (ChanBits'(s1_plane_q) == chan);
    is_hit     = ThresholdBits'(s1_pix_q) > cfg_i.pix_thresh;

    total_new = total_q;
    hits_new  = hits_q;
    if (take) begin
      total_new = (total_q == CountMax) ? CountMax : total_q + 1'b1;
      if (is_hit) begin
        hits_new = (hits_q == CountMax) ? CountMax : hits_q + 1'b1;
      end
    end
  end

  always_comb begin
    hits_d  = hits_q;
    total_d = total_q;
    if (s1_adv) begin
      // counts restart after the last beat of a frame
      hits_d  = s1_end_q ? '0 : hits_new;
      total_d = s1_end_q ? '0 : total_new;
    end
    s1_valid_d = in_acc | (s1_valid_q & ~frame_ready_i);
  end

  assign frame_valid_o     = s1_valid_q;
  assign frame_o.start_run = s1_start_q;
  assign frame_o.frame_end = s1_end_q;
  assign frame_o.hits      = hits_new;
  assign frame_o.total     = total_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hits_q     <= '0;
      total_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      hits_q     <= hits_d;
      total_q    <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_start_q <= start_run_i;
      s1_pix_q   <= pixel_value_i;
      s1_plane_q <= plane_i;
      s1_end_q   <= frame_end_i;
    end
  end

  a_hits_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q <= total_q)
    else $error("hit count exceeds pixel total");

endmodule

`default_nettype wire

// ===== design/fatsd_classify.sv =====
`default_nettype none

module fatsd_classify
  import fatsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        frame_valid_i,
  output logic             frame_ready_o,
  input  wire frame_t      frame_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             frame_foreground_o,
  output logic [15:0]      frame_number_o,
  output logic             found_any_o,
  output logic [15:0]      first_found_frame_o,
  output logic             early_hit_o,
  output logic             no_hit_o,
  output logic             in_range_o
);

  localparam logic [FrameIndexBits-1:0] FrameMax = '1;

  logic   s2_valid_q, s2_valid_d;
  frame_t s2_q;

  logic                      found_q, found_d;
  logic [FrameIndexBits-1:0] fcnt_q, fcnt_d, first_q, first_d;

  logic        out_valid_q, out_valid_d;
  logic        fg_q, found_out_q, t_in_q, t_out_q, in_rng_q;
  logic [15:0] num_q, first_out_q;

  logic                      out_ready, s2_adv, s2_load, res_load;
  logic                      fc_found, fg, t_in, t_out;
  logic [FrameIndexBits-1:0] fc_cnt, fc_first;
  logic [ProdBits-1:0]       lhs, rhs;

  assign out_ready     = ~out_valid_q | ~out_stall_i;
  assign s2_adv        = s2_valid_q & (~s2_q.frame_end | out_ready);
  assign frame_ready_o = ~s2_valid_q | s2_adv;
  assign s2_load       = frame_valid_i & frame_ready_o;
  assign res_load      = s2_adv & s2_q.frame_end;

  always_comb begin
    // run start clears the run state ahead of this beat
    fc_cnt   = s2_q.start_run ? '0   : fcnt_q;
    fc_found = s2_q.start_run ? 1'b0 : found_q;
    fc_first = s2_q.start_run ? '0   : first_q;

    lhs = ProdBits'({s2_q.hits, 16'h0000});
    rhs = ProdBits'(cfg_i.area_fraction) * ProdBits'(s2_q.total);
    fg  = (s2_q.total != '0) && (lhs > rhs);

    found_d = found_q;
    first_d = first_q;
    fcnt_d  = fcnt_q;
    if (s2_adv) begin
      found_d = fc_found;
      first_d = fc_first;
      fcnt_d  = fc_cnt;
      if (s2_q.frame_end) begin
        found_d = fc_found | fg;
        first_d = (fg && !fc_found) ? fc_cnt : fc_first;
        fcnt_d  = (fc_cnt == FrameMax) ? FrameMax : fc_cnt + 1'b1;
      end
    end

    t_in  = found_d && (first_d <= FrameIndexBits'(1));
    t_out = ~found_d;

    s2_valid_d  = s2_load | (s2_valid_q & ~s2_adv);
    out_valid_d = res_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      first_q     <= '0;
      fcnt_q      <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      first_q     <= first_d;
      fcnt_q      <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_q <= frame_i;
    end
    if (res_load) begin
      fg_q        <= fg;
      num_q       <= 16'(fc_cnt);
      found_out_q <= found_d;
      first_out_q <= 16'(first_d);
      t_in_q      <= t_in;
      t_out_q     <= t_out;
      in_rng_q    <= ~t_in & ~t_out;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frame_foreground_o  = fg_q;
  assign frame_number_o      = num_q;
  assign found_any_o         = found_out_q;
  assign first_found_frame_o = first_out_q;
  assign early_hit_o         = t_in_q;
  assign no_hit_o            = t_out_q;
  assign in_range_o          = in_rng_q;

  a_first_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> first_q == '0)
    else $error("first frame index set without a found frame");

  a_status_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot({t_in_q, t_out_q, in_rng_q}))
    else $error("range status not exactly one of three");

  a_frame_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv && !s2_q.start_run |=> fcnt_q >= $past(fcnt_q))
    else $error("frame counter went backwards without run start");

endmodule

`default_nettype wire

// ===== design/frame_area_threshold_surface_detect_core.sv =====
// Channel   Handshake                       Payload
// in        in_valid_i / in_stall_o         start_run_i pixel_value_i plane_i frame_end_i
// out       out_valid_o / out_stall_i       frame_foreground_o frame_number_o found_any_o
//                                           first_found_frame_o early_hit_o no_hit_o
//                                           in_range_o
// cfg       APB psel penable pwrite paddr   pwdata / prdata, pready tied high
//
// One sample per clock while in_stall_o is low; a result becomes valid once the frame's
// last beat has passed the input reg, then the classify reg, then the result reg.
// The classify stage holds the 17x25 area multiply and the 42-bit compare.
// Reset clears counts, run state and all valid flags; config takes reset values.
// Samples keep flowing while a result waits; in_stall_o rises only once the
// input and classify stages are both held behind a stalled result.
`default_nettype none

module frame_area_threshold_surface_detect_core
  import fatsd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ApbAddrBits-1:0] paddr,
  input  wire logic [ApbDataBits-1:0] pwdata,
  output logic      [ApbDataBits-1:0] prdata,
  output logic                        pready,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   start_run_i,
  input  wire logic [SampleBits-1:0]  pixel_value_i,
  input  wire logic [PlaneBits-1:0]   plane_i,
  input  wire logic                   frame_end_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        frame_foreground_o,
  output logic [15:0]                 frame_number_o,
  output logic                        found_any_o,
  output logic [15:0]                 first_found_frame_o,
  output logic                        early_hit_o,
  output logic                        no_hit_o,
  output logic                        in_range_o
);

  cfg_t   cfg;
  frame_t frame;
  logic   frame_valid, frame_ready;

  fatsd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fatsd_count u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_run_i   (start_run_i),
    .pixel_value_i (pixel_value_i),
    .plane_i       (plane_i),
    .frame_end_i   (frame_end_i),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  fatsd_classify u_classify (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .frame_valid_i       (frame_valid),
    .frame_ready_o       (frame_ready),
    .frame_i             (frame),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .frame_foreground_o  (frame_foreground_o),
    .frame_number_o      (frame_number_o),
    .found_any_o         (found_any_o),
    .first_found_frame_o (first_found_frame_o),
    .early_hit_o         (early_hit_o),
    .no_hit_o            (no_hit_o),
    .in_range_o          (in_range_o)
  );

endmodule

`default_nettype wire
